FILE: design/mi2sd_pkg.sv
// ---------------------------------------------------------------------------
// mi2sd_pkg
// Shared types and constants of the multichannel I2S frame deserializer.
// ---------------------------------------------------------------------------
package mi2sd_pkg;

   localparam int MAX_CHANNELS = 6;
   localparam int SYNC_TIMEOUT = 256;
   localparam int RUN_LEN      = 32;
   localparam int FRAME_LEN    = 2 * RUN_LEN;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int CHAN_W  = 3;
   localparam int CLK_POS = 7;
   localparam int PPS_POS = 6;
   localparam int POS_W   = $clog2(FRAME_LEN);
   localparam int CNT_W   =
      $clog2(((SYNC_TIMEOUT > RUN_LEN) ? SYNC_TIMEOUT : RUN_LEN) + 1);

   typedef enum logic [1:0] {
      STATUS_SAMPLE   = 2'd0,
      STATUS_TIMEOUT  = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef logic [MAX_CHANNELS-1:0][WORD_W-1:0] word_bank_type;

   // Event from the sync core: whether the byte on the input causes results
   typedef struct packed {
      logic       emit;
      status_type status;
      logic       pps_edge;
   } event_type;

endpackage

FILE: design/mi2sd_if.sv
// ---------------------------------------------------------------------------
// mi2sd channel interfaces
// Valid/ready channels for port bytes, results and the channel count CSR.
// ---------------------------------------------------------------------------
interface mi2sd_req_if import mi2sd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] port_byte;

   modport source (output valid, output port_byte, input ready);
   modport sink   (input valid, input port_byte, output ready);
endinterface

interface mi2sd_rsp_if import mi2sd_pkg::*; ;
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic [CHAN_W-1:0]        channel;
   logic signed [WORD_W-1:0] in_phase;
   logic signed [WORD_W-1:0] quadrature;
   logic                     pps_edge;
   logic                     last;

   modport source (output valid, output status, output channel, output in_phase,
                   output quadrature, output pps_edge, output last, input ready);
   modport sink   (input valid, input status, input channel, input in_phase,
                   input quadrature, input pps_edge, input last, output ready);
endinterface

interface mi2sd_csr_if import mi2sd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/multichannel_i2s_frame_deserializer_top.sv
// ---------------------------------------------------------------------------
// multichannel_i2s_frame_deserializer_top
// Six-line I2S-style frame deserializer with word clock sync search.
// ---------------------------------------------------------------------------
// Each req word is one byte of a parallel capture port (bit 7 word clock,
// bit 6 PPS, bits 0..5 serial data lines); the sync machine and the
// per-line shifters update from a single register stage. A byte is
// accepted every cycle except when it would produce results while the
// result buffer still holds words that have not been taken; frame-end
// bursts of channel_count rsp words (one per cycle while rsp ready is high)
// and status words leave through that buffer. With rsp ready held high a
// burst drains long before the next frame ends, so the only stall left is
// a clock mismatch status word raised within the first bytes after a
// burst: that byte waits until the burst's last word goes out. The csr
// word sets the number of decoded lines; 0 reads as 1 and values above
// six as six.
// ---------------------------------------------------------------------------
module multichannel_i2s_frame_deserializer_top import mi2sd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mi2sd_req_if.sink   req_ch,
   mi2sd_rsp_if.source rsp_ch,
   mi2sd_csr_if.sink   csr_ch
);

   logic [CHAN_W-1:0] chan_count_ff;
   logic [CHAN_W-1:0] chan_count_in;
   event_type         ev;
   word_bank_type     first_next;
   word_bank_type     second_next;
   logic              buf_free;
   logic              accept;

   // clamp the channel count once, at the write
   always_comb begin
      priority if (csr_ch.data == '0) begin
         chan_count_in = CHAN_W'(1);
      end else if (csr_ch.data > CHAN_W'(MAX_CHANNELS)) begin
         chan_count_in = CHAN_W'(MAX_CHANNELS);
      end else begin
         chan_count_in = csr_ch.data;
      end
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= CHAN_W'(1);
      end else if (csr_ch.valid) begin
         chan_count_ff <= chan_count_in;
      end
   end

   // hold a byte that produces results until the buffer can take them
   assign req_ch.ready = buf_free | ~ev.emit;
   assign accept       = req_ch.valid & req_ch.ready;

   mi2sd_sync_core u_sync_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .port_byte   (req_ch.port_byte),
      .ev          (ev),
      .first_next  (first_next),
      .second_next (second_next)
   );

   mi2sd_burst_out u_burst_out (
      .clock        (clock),
      .reset        (reset),
      .take         (accept & ev.emit),
      .ev           (ev),
      .first_words  (first_next),
      .second_words (second_next),
      .chan_count   (chan_count_ff),
      .free         (buf_free),
      .rsp_ch       (rsp_ch)
   );

endmodule

FILE: design/mi2sd_sync_core.sv
// ---------------------------------------------------------------------------
// mi2sd_sync_core
// Word clock sync search, frame position tracking and per-line shifting.
// ---------------------------------------------------------------------------
module mi2sd_sync_core import mi2sd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] port_byte,
   output event_type         ev,
   output word_bank_type     first_next,
   output word_bank_type     second_next
);

   typedef enum logic [2:0] {
      PH_WAIT_LOW  = 3'd0,
      PH_WAIT_HIGH = 3'd1,
      PH_HIGH1     = 3'd2,
      PH_LOW       = 3'd3,
      PH_HIGH2     = 3'd4,
      PH_SYNC      = 3'd5
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   word_bank_type    first_ff, second_ff;
   logic             level_ff, level_in;
   logic             seen_ff, seen_in;

   logic             clk_bit;
   logic             pps_bit;
   logic             second_half;
   logic             want;
   logic             seen_now;
   logic [CNT_W-1:0] need;
   logic [CNT_W-1:0] count_inc;

   assign clk_bit     = port_byte[CLK_POS];
   assign pps_bit     = port_byte[PPS_POS];
   assign second_half = pos_ff[POS_W-1];
   assign count_inc   = count_ff + CNT_W'(1);
   assign want        = (phase_ff != PH_LOW);
   assign need        = (phase_ff == PH_HIGH1) ? CNT_W'(RUN_LEN - 1) : CNT_W'(RUN_LEN);
   assign seen_now    = seen_ff | (pps_bit & ~level_ff);

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      level_in    = level_ff;
      seen_in     = seen_ff;
      first_next  = first_ff;
      second_next = second_ff;
      ev.emit     = 1'b0;
      ev.status   = STATUS_SAMPLE;
      ev.pps_edge = 1'b0;
      unique case (phase_ff)
         PH_WAIT_HIGH: begin
            if (count_ff >= CNT_W'(SYNC_TIMEOUT)) begin
               ev.emit   = 1'b1;
               ev.status = STATUS_TIMEOUT;
               phase_in  = PH_WAIT_LOW;
               count_in  = '0;
               pos_in    = '0;
            end else if (clk_bit) begin
               phase_in = PH_HIGH1;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_HIGH1, PH_LOW, PH_HIGH2: begin
            if (clk_bit != want) begin
               phase_in = PH_WAIT_LOW;
               count_in = '0;
               pos_in   = '0;
            end else if (count_inc >= need) begin
               count_in = '0;
               unique case (phase_ff)
                  PH_HIGH1: phase_in = PH_LOW;
                  PH_LOW:   phase_in = PH_HIGH2;
                  default: begin
                     phase_in = PH_SYNC;
                     pos_in   = '0;
                     level_in = 1'b0;
                     seen_in  = 1'b0;
                  end
               endcase
            end else begin
               count_in = count_inc;
            end
         end
         PH_SYNC: begin
            if (clk_bit != second_half) begin
               ev.emit   = 1'b1;
               ev.status = STATUS_MISMATCH;
               phase_in  = PH_WAIT_LOW;
               count_in  = '0;
               pos_in    = '0;
            end else begin
               level_in = pps_bit;
               seen_in  = seen_now;
               for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                  if (second_half) begin
                     second_next[ch] = {second_ff[ch][WORD_W-2:0], port_byte[ch]};
                  end else begin
                     first_next[ch] = {first_ff[ch][WORD_W-2:0], port_byte[ch]};
                  end
               end
               if (pos_ff == POS_W'(FRAME_LEN - 1)) begin
                  ev.emit     = 1'b1;
                  ev.pps_edge = seen_now;
                  pos_in      = '0;
                  seen_in     = 1'b0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         default: begin
            // wait for low clock; unknown codes behave the same
            if (count_ff >= CNT_W'(SYNC_TIMEOUT)) begin
               ev.emit   = 1'b1;
               ev.status = STATUS_TIMEOUT;
               phase_in  = PH_WAIT_LOW;
               count_in  = '0;
               pos_in    = '0;
            end else if (!clk_bit) begin
               phase_in = PH_WAIT_HIGH;
               count_in = '0;
            end else begin
               phase_in = PH_WAIT_LOW;
               count_in = count_inc;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_LOW;
         count_ff <= '0;
         pos_ff   <= '0;
         level_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         level_ff <= level_in;
         seen_ff  <= seen_in;
      end
   end

   // every word is fully rewritten within a frame before it is read
   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff  <= first_next;
         second_ff <= second_next;
      end
   end

endmodule

FILE: design/mi2sd_burst_out.sv
// ---------------------------------------------------------------------------
// mi2sd_burst_out
// Result buffer: holds a frame's words, sends one per channel or one status.
// ---------------------------------------------------------------------------
module mi2sd_burst_out import mi2sd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  event_type         ev,
   input  word_bank_type     first_words,
   input  word_bank_type     second_words,
   input  logic [CHAN_W-1:0] chan_count,
   output logic              free,
   mi2sd_rsp_if.source       rsp_ch
);

   logic              busy_ff;
   status_type        status_ff;
   logic              pps_ff;
   logic [CHAN_W-1:0] n_ff;
   logic [CHAN_W-1:0] k_ff;
   word_bank_type     ip_ff, q_ff;
   logic              is_last;
   logic              is_sample;
   logic              handoff;

   assign is_last   = (k_ff == n_ff - CHAN_W'(1));
   assign is_sample = (status_ff == STATUS_SAMPLE);
   assign handoff   = rsp_ch.valid & rsp_ch.ready;
   assign free      = ~busy_ff | (handoff & is_last);

   assign rsp_ch.valid      = busy_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.channel    = k_ff;
   assign rsp_ch.in_phase   = is_sample ? ip_ff[k_ff] : '0;
   assign rsp_ch.quadrature = is_sample ? q_ff[k_ff] : '0;
   assign rsp_ch.pps_edge   = pps_ff;
   assign rsp_ch.last       = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
         n_ff    <= CHAN_W'(1);
      end else if (take) begin
         busy_ff <= 1'b1;
         k_ff    <= '0;
         n_ff    <= (ev.status == STATUS_SAMPLE) ? chan_count : CHAN_W'(1);
      end else if (handoff) begin
         if (is_last) begin
            busy_ff <= 1'b0;
         end else begin
            k_ff <= k_ff + CHAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= ev.status;
         pps_ff    <= ev.pps_edge;
         ip_ff     <= first_words;
         q_ff      <= second_words;
      end
   end

endmodule
